/* src/tclr_pkg.sv */
`default_nettype none
package tclr_pkg;

  localparam int STORE_CELLS_DEF = 4096;
  localparam int MAX_COLUMNS_DEF = 256;

  localparam int CODE_W     = 8;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 12;
  localparam int ROWS_W     = 13;
  localparam int CELL_ADR_W = 12;
  localparam int ADDR_MAX_W = 16;
  localparam int CFG_DATA_W = 13;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam logic [COL_W-1:0]  COLS_RESET = 9'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd51;
  localparam logic [ROWS_W-1:0] ROW_LIMIT  = 13'd4096;

  typedef struct packed {
    logic                  clr;
    logic                  wr;
    logic [ADDR_MAX_W-1:0] addr;
    logic [COL_W-1:0]      count;
    logic [CODE_W-1:0]     data;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* src/tclr_rem_unit.sv */
`default_nettype none
module tclr_rem_unit #(
  parameter int DIVD_W = 22,
  parameter int DIVS_W = 17
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   done,
  output logic      [DIVS_W-1:0] rem
);
  import tclr_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W-1:0] rem_step;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_step = DIVS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_step = trial[DIVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* src/tclr_cell_mem.sv */
`default_nettype none
module tclr_cell_mem #(
  parameter int STORE_CELLS = tclr_pkg::STORE_CELLS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tclr_pkg::cell_cmd_t cmd,
  output logic                     busy
);
  import tclr_pkg::*;

  localparam int SADDR_W = $clog2(STORE_CELLS);
  localparam int CNT_W   = $clog2(STORE_CELLS + 1);

  logic [CODE_W-1:0]  mem [STORE_CELLS];
  logic [SADDR_W-1:0] ptr_r;
  logic [CNT_W-1:0]   left_r;
  logic [SADDR_W-1:0] ptr_inc;
  logic [CNT_W-1:0]   clr_len;

  assign ptr_inc = (ptr_r == SADDR_W'(STORE_CELLS - 1)) ? '0 : ptr_r + SADDR_W'(1);
  assign clr_len = (32'(cmd.count) > STORE_CELLS) ? CNT_W'(STORE_CELLS)
                                                  : CNT_W'(cmd.count);
  assign busy    = (left_r != '0);

  // zero sweep: whole store after reset, one row on request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      left_r <= CNT_W'(STORE_CELLS);
    end else if (busy) begin
      ptr_r  <= ptr_inc;
      left_r <= left_r - CNT_W'(1);
    end else if (cmd.clr) begin
      ptr_r  <= cmd.addr[SADDR_W-1:0];
      left_r <= clr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[ptr_r] <= '0;
    end else if (cmd.wr) begin
      mem[cmd.addr[SADDR_W-1:0]] <= cmd.data;
    end
  end

endmodule
`default_nettype wire

/* src/text_console_line_ring_writer_core.sv */
`default_nettype none
// Character cell store for a scrolling text console. One beat on the in_ channel
// carries a character code; one beat on the out_ channel reports how it was handled.
// After reset the block zeroes the whole store and holds in_stall high
// meanwhile; configuration writes are taken throughout. Items are handled one at
// a time: a newline advances the cursor row, a plain character forms its cell
// address and writes it, and a wrap to a new line first advances the row. Reaching
// the oldest row clears that row through the store's single write port at one
// cell per cycle. A row index advanced to past rows_in_use is reduced by the
// bit-serial remainder unit. Cell addresses wrap at STORE_CELLS, which must be
// a power of two. A finished result waits in the output register while the next
// beat is accepted.
module text_console_line_ring_writer_core #(
  parameter int STORE_CELLS = tclr_pkg::STORE_CELLS_DEF,
  parameter int MAX_COLUMNS = tclr_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [tclr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tclr_pkg::CODE_W-1:0]     in_char_code,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_wrote_cell,
  output logic      [tclr_pkg::CELL_ADR_W-1:0] out_cell_address,
  output logic                                 out_row_cleared,
  output logic      [tclr_pkg::ROW_W-1:0]      out_cursor_row,
  output logic      [tclr_pkg::COL_W-1:0]      out_cursor_col,
  output logic      [tclr_pkg::ROW_W-1:0]      out_oldest_row_next
);
  import tclr_pkg::*;

  localparam int SADDR_W = $clog2(STORE_CELLS);
  localparam int BASE_W  = ROW_W + COL_W;
  localparam int SUM_W   = BASE_W + 1;
  localparam int DIVS_W  = ROWS_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CUR_ADV, S_CUR_DIV, S_MUL, S_ADDR,
    S_CLEAR, S_OLD_ADV, S_OLD_DIV, S_DONE
  } state_t;

  state_t             state_r;
  logic [COL_W-1:0]   cfg_cols_r;
  logic [ROWS_W-1:0]  cfg_rows_r;
  logic [CODE_W-1:0]  code_r;
  logic [COL_W-1:0]   column_r;
  logic [ROW_W-1:0]   cur_row_r;
  logic [ROW_W-1:0]   oldest_r;
  logic [BASE_W-1:0]  base_r;
  logic               match_r;
  logic               cleared_r;
  logic [SADDR_W-1:0] addr_r;

  logic                  out_valid_r;
  logic                  out_wrote_r;
  logic [CELL_ADR_W-1:0] out_addr_r;
  logic                  out_cleared_r;
  logic [ROW_W-1:0]      out_row_r;
  logic [COL_W-1:0]      out_col_r;
  logic [ROW_W-1:0]      out_oldest_r;

  logic [COL_W-1:0]      cols_eff;
  logic [ROWS_W-1:0]     rows_eff;
  logic [ROWS_W-1:0]     cur_inc;
  logic [ROWS_W-1:0]     old_inc;
  logic                  cur_fast;
  logic                  old_fast;
  logic [ROW_W-1:0]      cur_next;
  logic [ROW_W-1:0]      old_next;
  logic [SUM_W-1:0]      sum;
  logic                  need_clr;
  logic                  is_nl;
  logic                  in_accept;
  logic                  out_free;
  logic [ADDR_MAX_W-1:0] addr_ext;

  logic                  div_start;
  logic [ROWS_W-1:0]     div_dividend;
  logic [DIVS_W-1:0]     div_divisor;
  logic                  div_done;
  logic [DIVS_W-1:0]     div_rem;

  cell_cmd_t             mem_cmd;
  logic                  mem_busy;

  always_comb begin
    if (cfg_cols_r == '0) begin
      cols_eff = COL_W'(1);
    end else if (32'(cfg_cols_r) > MAX_COLUMNS) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = cfg_cols_r;
    end
    if (cfg_rows_r == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (cfg_rows_r > ROW_LIMIT) begin
      rows_eff = ROW_LIMIT;
    end else begin
      rows_eff = cfg_rows_r;
    end
  end

  assign cur_inc   = {1'b0, cur_row_r} + ROWS_W'(1);
  assign old_inc   = {1'b0, oldest_r} + ROWS_W'(1);
  assign cur_fast  = (cur_inc <= rows_eff);
  assign old_fast  = (old_inc <= rows_eff);
  assign cur_next  = (cur_inc == rows_eff) ? '0 : cur_inc[ROW_W-1:0];
  assign old_next  = (old_inc == rows_eff) ? '0 : old_inc[ROW_W-1:0];
  assign sum       = {1'b0, base_r} + SUM_W'(column_r);
  assign need_clr  = match_r && !cleared_r;
  assign is_nl     = (code_r == NEWLINE_CODE);
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign addr_ext  = ADDR_MAX_W'(addr_r);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = cur_inc;
    div_divisor  = DIVS_W'(rows_eff);
    mem_cmd      = '0;
    mem_cmd.count = cols_eff;
    mem_cmd.data  = code_r;
    unique case (state_r)
      S_CUR_ADV: begin
        div_start = !cur_fast;
      end
      S_OLD_ADV: begin
        div_start    = !old_fast;
        div_dividend = old_inc;
      end
      S_ADDR: begin
        if (need_clr) begin
          mem_cmd.clr  = 1'b1;
          mem_cmd.addr = ADDR_MAX_W'(base_r[SADDR_W-1:0]);
        end else begin
          mem_cmd.wr   = 1'b1;
          mem_cmd.addr = ADDR_MAX_W'(sum[SADDR_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= COLS_RESET;
      cfg_rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS: cfg_cols_r <= cfg_wdata[COL_W-1:0];
        CFG_ROWS: cfg_rows_r <= cfg_wdata[ROWS_W-1:0];
        default:  cfg_cols_r <= cfg_cols_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      column_r    <= '0;
      cur_row_r   <= '0;
      oldest_r    <= ROW_W'(1);
      cleared_r   <= 1'b0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          if (!mem_busy) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            code_r    <= in_char_code;
            cleared_r <= 1'b0;
            addr_r    <= '0;
            if (in_char_code == NEWLINE_CODE || column_r >= cols_eff) begin
              state_r <= S_CUR_ADV;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_CUR_ADV: begin
          column_r <= '0;
          if (cur_fast) begin
            cur_row_r <= cur_next;
            state_r   <= is_nl ? S_DONE : S_MUL;
          end else begin
            state_r <= S_CUR_DIV;
          end
        end
        S_CUR_DIV: begin
          if (div_done) begin
            cur_row_r <= div_rem[ROW_W-1:0];
            state_r   <= is_nl ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          base_r  <= BASE_W'(cur_row_r) * BASE_W'(cols_eff);
          match_r <= (cur_row_r == oldest_r);
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          if (need_clr) begin
            state_r <= S_CLEAR;
          end else begin
            addr_r   <= mem_cmd.addr[SADDR_W-1:0];
            column_r <= column_r + COL_W'(1);
            state_r  <= S_DONE;
          end
        end
        S_CLEAR: begin
          if (!mem_busy) begin
            cleared_r <= 1'b1;
            state_r   <= S_OLD_ADV;
          end
        end
        S_OLD_ADV: begin
          if (old_fast) begin
            oldest_r <= old_next;
            state_r  <= S_ADDR;
          end else begin
            state_r <= S_OLD_DIV;
          end
        end
        S_OLD_DIV: begin
          if (div_done) begin
            oldest_r <= div_rem[ROW_W-1:0];
            state_r  <= S_ADDR;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_wrote_r   <= !is_nl;
            out_addr_r    <= addr_ext[CELL_ADR_W-1:0];
            out_cleared_r <= cleared_r;
            out_row_r     <= cur_row_r;
            out_col_r     <= column_r;
            out_oldest_r  <= oldest_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  tclr_rem_unit #(
    .DIVD_W (ROWS_W),
    .DIVS_W (DIVS_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  tclr_cell_mem #(
    .STORE_CELLS (STORE_CELLS)
  ) u_cells (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mem_cmd),
    .busy  (mem_busy)
  );

  assign out_valid           = out_valid_r;
  assign out_wrote_cell      = out_wrote_r;
  assign out_cell_address    = out_addr_r;
  assign out_row_cleared     = out_cleared_r;
  assign out_cursor_row      = out_row_r;
  assign out_cursor_col      = out_col_r;
  assign out_oldest_row_next = out_oldest_r;

endmodule
`default_nettype wire
